/* sv/mer_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, codes and microcode word layout for the midpoint ellipse rasterizer.
// No dependencies; every other file imports this package.
package mer_pkg;

	localparam int RADIUS_BITS   = 10;
	localparam int COORD_BITS    = 13;
	localparam int REG_BITS      = 11;
	localparam int CFG_DATA_BITS = (RADIUS_BITS > REG_BITS) ? RADIUS_BITS : REG_BITS;
	localparam int CFG_IDX_BITS  = 3;
	localparam int R2_BITS       = 2 * RADIUS_BITS;
	localparam int SQ_BITS       = 2 * (RADIUS_BITS + 1);
	localparam int MUL_BITS      = SQ_BITS + 2;
	localparam int DEC_BITS      = 2 * MUL_BITS;
	localparam int PC_BITS       = 5;

	localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_X     = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_Y     = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X     = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y     = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_MAX_Y = CFG_IDX_BITS'(4);

	localparam logic [REG_BITS-1:0] SCREEN_MAX_Y_RESET = REG_BITS'(479);

	typedef enum logic [PC_BITS-1:0] {
		ST_IDLE = 5'd0,
		ST_SQ_A,
		ST_SQ_B,
		ST_INIT0,
		ST_INIT1,
		ST_INIT2,
		ST_INIT3,
		ST_START,
		ST_ADV,
		ST_TEST0,
		ST_TEST1,
		ST_R1_BRANCH,
		ST_R1_BASE,
		ST_R1_DIAG,
		ST_R1_COMMIT,
		ST_SW0,
		ST_SW1,
		ST_SW2,
		ST_SW3,
		ST_SW4,
		ST_SW5,
		ST_SW_COMMIT,
		ST_R2_BASE,
		ST_R2_COND,
		ST_R2_DIAG,
		ST_R2_COMMIT,
		ST_EMIT
	} step_t;

	typedef enum logic [3:0] {
		SRC_ONE,
		SRC_RX,
		SRC_RY,
		SRC_A2,
		SRC_B2,
		SRC_SQ,
		SRC_XP1,
		SRC_X2P1,
		SRC_X2P2,
		SRC_X2P3,
		SRC_YM1,
		SRC_Y2M1,
		SRC_2M2Y,
		SRC_3M2Y
	} src_t;

	typedef enum logic [2:0] {
		MD_NONE,
		MD_PROD,
		MD_A2,
		MD_B2,
		MD_SQ
	} mdst_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_SET,
		ACC_ADD,
		ACC_SUB,
		ACC_DEC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ITEM,
		COND_IDLE_ADV,
		COND_NOT_RESTART,
		COND_REGION2,
		COND_ACC_NONNEG,
		COND_DEC_NEG,
		COND_DEC_NONNEG
	} cond_t;

	typedef struct packed {
		src_t       src_a;
		src_t       src_b;
		mdst_t      mdst;
		acc_op_t    acc_op;
		logic [1:0] shift;
		logic       inc_x;
		logic       dec_y;
		logic       commit;
		logic       start;
		logic       set_r2;
		logic       emit;
		cond_t      cond;
		step_t      target;
	} ctl_t;

	typedef struct packed {
		logic restart;
		logic active;
		logic region2;
		logic dec_neg;
		logic acc_neg;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic ready;
		logic run;
	} seq_t;

	localparam ctl_t CTL_NOP = '{
		src_a:  SRC_ONE,
		src_b:  SRC_ONE,
		mdst:   MD_NONE,
		acc_op: ACC_HOLD,
		shift:  2'd0,
		inc_x:  1'b0,
		dec_y:  1'b0,
		commit: 1'b0,
		start:  1'b0,
		set_r2: 1'b0,
		emit:   1'b0,
		cond:   COND_NEVER,
		target: ST_IDLE
	};

endpackage

/* sv/mer_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and pixel result items.
// Depends on mer_pkg for the coordinate width.
interface mer_cmd_if;
	import mer_pkg::*;
	logic valid;
	logic ready;
	logic restart;
	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface mer_pixel_if;
	import mer_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_right;
	logic signed [COORD_BITS-1:0] x_left;
	logic signed [COORD_BITS-1:0] y_upper;
	logic signed [COORD_BITS-1:0] y_lower;
	logic                         last_point;
	modport source(output valid, output x_right, output x_left, output y_upper,
		output y_lower, output last_point, input ready);
	modport sink(input valid, input x_right, input x_left, input y_upper,
		input y_lower, input last_point, output ready);
endinterface

/* sv/midpoint_ellipse_rasterizer.sv */
`timescale 1ns / 1ps
// Midpoint ellipse rasterizer top level: microcode ROM, sequencer and datapath.
// Depends on mer_pkg, mer_if.sv, mer_ucode_rom, mer_sequencer and mer_datapath.
//
// Usage: write radius_x, radius_y, center_x, center_y and screen_max_y through the
// cfg_we / cfg_index / cfg_wdata port while the block is idle. Send a cmd item with
// restart=1 to start a curve at its top point; each later item with restart=0 walks one
// point further. Each such item gives one pixel item carrying the four mirrored
// coordinates; last_point marks the point with zero vertical offset, after which
// advance items give no result until the next restart.
// A restart runs the squaring and setup steps; a normal step runs the update steps of its
// region, and a step that crosses from region one to region two also runs the switch
// steps. An advance with no curve running goes back to idle with no result. The next cmd
// item is taken the cycle after the result is loaded. Every product goes through a single
// shared 24x24 multiplier, at most one per step.
// Reset clears the curve state and the radii and centers, and sets screen_max_y to 479.
// A result waits in the output register while the receiver stalls; the next cmd item is
// still taken, and its own result holds at the emit step until the register frees.
module midpoint_ellipse_rasterizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mer_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	mer_cmd_if.sink                            cmd,
	mer_pixel_if.source                        pixel
);
	import mer_pkg::*;

	step_t pc;
	ctl_t  ctl;
	stat_t stat;
	seq_t  seq;
	logic  item_accept;

	assign cmd.ready   = seq.ready;
	assign item_accept = cmd.valid && seq.ready;

	mer_ucode_rom u_rom (
		.pc  (pc),
		.ctl (ctl)
	);

	mer_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.item_valid (cmd.valid),
		.pc         (pc),
		.seq        (seq)
	);

	mer_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.run          (seq.run),
		.item_accept  (item_accept),
		.item_restart (cmd.restart),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.stat         (stat),
		.pixel        (pixel)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("cmd ready right after an accepted item");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel.valid) |-> $past(ctl.emit))
		else $error("pixel item loaded outside the emit step");

	a_start_sets_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start && seq.run |=> stat.active && !stat.region2)
		else $error("curve start did not leave an active region-one walk");

endmodule

/* sv/mer_ucode_rom.sv */
`timescale 1ns / 1ps
// Microprogram ROM: one control word per sequencer step.
// Depends on mer_pkg for the control word layout and step names.
module mer_ucode_rom (
	input  mer_pkg::step_t pc,
	output mer_pkg::ctl_t  ctl
);
	import mer_pkg::*;

	ctl_t w;

	always_comb begin
		w = CTL_NOP;
		unique case (pc)
			ST_IDLE: begin
				w.cond = COND_NO_ITEM;
				w.target = ST_IDLE;
			end
			ST_SQ_A: begin
				w.src_a = SRC_RX; w.src_b = SRC_RX; w.mdst = MD_A2;
				w.cond = COND_IDLE_ADV; w.target = ST_IDLE;
			end
			ST_SQ_B: begin
				w.src_a = SRC_RY; w.src_b = SRC_RY; w.mdst = MD_B2;
				w.cond = COND_NOT_RESTART; w.target = ST_ADV;
			end
			ST_INIT0: begin
				w.src_a = SRC_B2; w.src_b = SRC_ONE; w.mdst = MD_PROD;
			end
			ST_INIT1: begin
				w.src_a = SRC_A2; w.src_b = SRC_ONE; w.mdst = MD_PROD;
				w.acc_op = ACC_SET; w.shift = 2'd2;
			end
			ST_INIT2: begin
				w.src_a = SRC_A2; w.src_b = SRC_RY; w.mdst = MD_PROD;
				w.acc_op = ACC_ADD; w.shift = 2'd0;
			end
			ST_INIT3: begin
				w.acc_op = ACC_SUB; w.shift = 2'd2;
			end
			ST_START: begin
				w.start = 1'b1;
				w.cond = COND_ALWAYS; w.target = ST_EMIT;
			end
			ST_ADV: begin
				w.src_a = SRC_B2; w.src_b = SRC_XP1; w.mdst = MD_PROD;
				w.cond = COND_REGION2; w.target = ST_R2_BASE;
			end
			ST_TEST0: begin
				w.src_a = SRC_A2; w.src_b = SRC_Y2M1; w.mdst = MD_PROD;
				w.acc_op = ACC_SET; w.shift = 2'd1;
			end
			ST_TEST1: begin
				w.acc_op = ACC_SUB; w.shift = 2'd0;
			end
			ST_R1_BRANCH: begin
				w.src_a = SRC_B2; w.src_b = SRC_X2P3; w.mdst = MD_PROD;
				w.cond = COND_ACC_NONNEG; w.target = ST_SW0;
			end
			ST_R1_BASE: begin
				w.src_a = SRC_A2; w.src_b = SRC_2M2Y; w.mdst = MD_PROD;
				w.acc_op = ACC_DEC_ADD; w.shift = 2'd2;
				w.cond = COND_DEC_NEG; w.target = ST_R1_COMMIT;
			end
			ST_R1_DIAG: begin
				w.acc_op = ACC_ADD; w.shift = 2'd2; w.dec_y = 1'b1;
			end
			ST_R1_COMMIT: begin
				w.commit = 1'b1; w.inc_x = 1'b1;
				w.cond = COND_ALWAYS; w.target = ST_EMIT;
			end
			ST_SW0: begin
				w.src_a = SRC_X2P1; w.src_b = SRC_X2P1; w.mdst = MD_SQ;
			end
			ST_SW1: begin
				w.src_a = SRC_B2; w.src_b = SRC_SQ; w.mdst = MD_PROD;
			end
			ST_SW2: begin
				w.src_a = SRC_YM1; w.src_b = SRC_YM1; w.mdst = MD_SQ;
				w.acc_op = ACC_SET; w.shift = 2'd0;
			end
			ST_SW3: begin
				w.src_a = SRC_A2; w.src_b = SRC_SQ; w.mdst = MD_PROD;
			end
			ST_SW4: begin
				w.src_a = SRC_A2; w.src_b = SRC_B2; w.mdst = MD_PROD;
				w.acc_op = ACC_ADD; w.shift = 2'd2;
			end
			ST_SW5: begin
				w.acc_op = ACC_SUB; w.shift = 2'd2;
			end
			ST_SW_COMMIT: begin
				w.commit = 1'b1; w.set_r2 = 1'b1;
			end
			ST_R2_BASE: begin
				w.src_a = SRC_A2; w.src_b = SRC_3M2Y; w.mdst = MD_PROD;
			end
			ST_R2_COND: begin
				w.src_a = SRC_B2; w.src_b = SRC_X2P2; w.mdst = MD_PROD;
				w.acc_op = ACC_DEC_ADD; w.shift = 2'd2;
				w.cond = COND_DEC_NONNEG; w.target = ST_R2_COMMIT;
			end
			ST_R2_DIAG: begin
				w.acc_op = ACC_ADD; w.shift = 2'd2; w.inc_x = 1'b1;
			end
			ST_R2_COMMIT: begin
				w.commit = 1'b1; w.dec_y = 1'b1;
				w.cond = COND_ALWAYS; w.target = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_ALWAYS; w.target = ST_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = ST_IDLE;
			end
		endcase
	end

	assign ctl = w;

endmodule

/* sv/mer_sequencer.sv */
`timescale 1ns / 1ps
// Step counter with conditional jumps; holds at the emit step while the output is full.
// Depends on mer_pkg for step, control word and status types.
module mer_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  mer_pkg::ctl_t  ctl,
	input  mer_pkg::stat_t stat,
	input  logic           item_valid,
	output mer_pkg::step_t pc,
	output mer_pkg::seq_t  seq
);
	import mer_pkg::*;

	step_t pc_q;
	step_t pc_next;
	logic  take;
	logic  run;

	always_comb begin
		unique case (ctl.cond)
			COND_NEVER:       take = 1'b0;
			COND_ALWAYS:      take = 1'b1;
			COND_NO_ITEM:     take = !item_valid;
			COND_IDLE_ADV:    take = !stat.restart && !stat.active;
			COND_NOT_RESTART: take = !stat.restart;
			COND_REGION2:     take = stat.region2;
			COND_ACC_NONNEG:  take = !stat.acc_neg;
			COND_DEC_NEG:     take = stat.dec_neg;
			COND_DEC_NONNEG:  take = !stat.dec_neg;
			default:          take = 1'b0;
		endcase
	end

	assign run = !(ctl.emit && stat.out_busy);

	always_comb begin
		priority if (!run) begin
			pc_next = pc_q;
		end else if (take) begin
			pc_next = ctl.target;
		end else begin
			pc_next = step_t'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign pc = pc_q;
	assign seq.ready = (pc_q == ST_IDLE);
	assign seq.run = run;

endmodule

/* sv/mer_datapath.sv */
`timescale 1ns / 1ps
// Shared multiplier, accumulator, curve state, configuration registers and output register.
// Depends on mer_pkg and the pixel channel interface in mer_if.sv.
module mer_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mer_pkg::ctl_t                      ctl,
	input  logic                               run,
	input  logic                               item_accept,
	input  logic                               item_restart,
	input  logic                               cfg_we,
	input  logic [mer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mer_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output mer_pkg::stat_t                     stat,
	mer_pixel_if.source                        pixel
);
	import mer_pkg::*;

	function automatic logic signed [MUL_BITS-1:0] pick(
		input src_t s,
		input logic signed [MUL_BITS-1:0] rx,
		input logic signed [MUL_BITS-1:0] ry,
		input logic signed [MUL_BITS-1:0] a2,
		input logic signed [MUL_BITS-1:0] b2,
		input logic signed [MUL_BITS-1:0] sq,
		input logic signed [MUL_BITS-1:0] x,
		input logic signed [MUL_BITS-1:0] y
	);
		logic signed [MUL_BITS-1:0] v;
		unique case (s)
			SRC_ONE:  v = MUL_BITS'(1);
			SRC_RX:   v = rx;
			SRC_RY:   v = ry;
			SRC_A2:   v = a2;
			SRC_B2:   v = b2;
			SRC_SQ:   v = sq;
			SRC_XP1:  v = x + MUL_BITS'(1);
			SRC_X2P1: v = (x <<< 1) + MUL_BITS'(1);
			SRC_X2P2: v = (x <<< 1) + MUL_BITS'(2);
			SRC_X2P3: v = (x <<< 1) + MUL_BITS'(3);
			SRC_YM1:  v = y - MUL_BITS'(1);
			SRC_Y2M1: v = (y <<< 1) - MUL_BITS'(1);
			SRC_2M2Y: v = MUL_BITS'(2) - (y <<< 1);
			SRC_3M2Y: v = MUL_BITS'(3) - (y <<< 1);
			default:  v = '0;
		endcase
		return v;
	endfunction

	logic [RADIUS_BITS-1:0] rx_q, ry_q;
	logic [REG_BITS-1:0]    cx_q, cy_q, smy_q;
	logic [RADIUS_BITS-1:0] ox_q, oy_q;
	logic signed [DEC_BITS-1:0] dec_q;
	logic region2_q, active_q, restart_q;

	logic [R2_BITS-1:0]         a2_q, b2_q;
	logic [SQ_BITS-1:0]         sq_q;
	logic signed [DEC_BITS-1:0] prod_q, acc_q;

	logic signed [MUL_BITS-1:0] rx_w, ry_w, a2_w, b2_w, sq_w, x_w, y_w;
	logic signed [MUL_BITS-1:0] op_a, op_b;
	logic signed [DEC_BITS-1:0] prod_w, term_w;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] x_right_q, x_left_q, y_upper_q, y_lower_q;
	logic                         last_q;
	logic [COORD_BITS-1:0]        cx_w, cy_w, smy_w, ox_w, oy_w;
	logic                         do_emit;

	assign rx_w = MUL_BITS'(rx_q);
	assign ry_w = MUL_BITS'(ry_q);
	assign a2_w = MUL_BITS'(a2_q);
	assign b2_w = MUL_BITS'(b2_q);
	assign sq_w = MUL_BITS'(sq_q);
	assign x_w  = MUL_BITS'(ox_q);
	assign y_w  = MUL_BITS'(oy_q);

	assign op_a   = pick(ctl.src_a, rx_w, ry_w, a2_w, b2_w, sq_w, x_w, y_w);
	assign op_b   = pick(ctl.src_b, rx_w, ry_w, a2_w, b2_w, sq_w, x_w, y_w);
	assign prod_w = DEC_BITS'(op_a) * DEC_BITS'(op_b);
	assign term_w = prod_q <<< ctl.shift;

	assign do_emit = ctl.emit && run;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q  <= '0;
			ry_q  <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			smy_q <= SCREEN_MAX_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS_X:     rx_q  <= cfg_wdata[RADIUS_BITS-1:0];
				CFG_RADIUS_Y:     ry_q  <= cfg_wdata[RADIUS_BITS-1:0];
				CFG_CENTER_X:     cx_q  <= cfg_wdata[REG_BITS-1:0];
				CFG_CENTER_Y:     cy_q  <= cfg_wdata[REG_BITS-1:0];
				CFG_SCREEN_MAX_Y: smy_q <= cfg_wdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// curve state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q      <= '0;
			oy_q      <= '0;
			dec_q     <= '0;
			region2_q <= 1'b0;
			active_q  <= 1'b0;
			restart_q <= 1'b0;
		end else begin
			if (item_accept) begin
				restart_q <= item_restart;
			end
			if (run) begin
				if (ctl.start) begin
					ox_q      <= '0;
					oy_q      <= ry_q;
					region2_q <= 1'b0;
					active_q  <= 1'b1;
					dec_q     <= acc_q;
				end else begin
					if (ctl.commit) begin
						dec_q <= acc_q;
					end
					if (ctl.inc_x) begin
						ox_q <= ox_q + 1'b1;
					end
					if (ctl.dec_y) begin
						oy_q <= oy_q - 1'b1;
					end
					if (ctl.set_r2) begin
						region2_q <= 1'b1;
					end
				end
				if (ctl.emit && (oy_q == '0)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// multiplier destinations and accumulator
	always_ff @(posedge clk) begin
		if (run) begin
			unique case (ctl.mdst)
				MD_NONE: ;
				MD_PROD: prod_q <= prod_w;
				MD_A2:   a2_q   <= prod_w[R2_BITS-1:0];
				MD_B2:   b2_q   <= prod_w[R2_BITS-1:0];
				MD_SQ:   sq_q   <= prod_w[SQ_BITS-1:0];
				default: ;
			endcase
			unique case (ctl.acc_op)
				ACC_HOLD:    ;
				ACC_SET:     acc_q <= term_w;
				ACC_ADD:     acc_q <= acc_q + term_w;
				ACC_SUB:     acc_q <= acc_q - term_w;
				ACC_DEC_ADD: acc_q <= dec_q + term_w;
				default: ;
			endcase
		end
	end

	// output register
	assign cx_w  = COORD_BITS'(cx_q);
	assign cy_w  = COORD_BITS'(cy_q);
	assign smy_w = COORD_BITS'(smy_q);
	assign ox_w  = COORD_BITS'(ox_q);
	assign oy_w  = COORD_BITS'(oy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			x_right_q <= cx_w + ox_w;
			x_left_q  <= cx_w - ox_w;
			y_upper_q <= smy_w - (cy_w + oy_w);
			y_lower_q <= smy_w - cy_w + oy_w;
			last_q    <= (oy_q == '0);
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.x_right    = x_right_q;
	assign pixel.x_left     = x_left_q;
	assign pixel.y_upper    = y_upper_q;
	assign pixel.y_lower    = y_lower_q;
	assign pixel.last_point = last_q;

	assign stat.restart  = restart_q;
	assign stat.active   = active_q;
	assign stat.region2  = region2_q;
	assign stat.dec_neg  = dec_q[DEC_BITS-1];
	assign stat.acc_neg  = acc_q[DEC_BITS-1];
	assign stat.out_busy = out_valid_q && !pixel.ready;

endmodule

/* tb/mer_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the midpoint ellipse rasterizer: tracks the register writes, walks the
// curve for each accepted cmd item and matches pixel items in order. Uses mer_pkg, mer_if.sv.
module mer_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mer_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mer_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	mer_cmd_if                                cmd,
	mer_pixel_if                              pixel,
	output int unsigned                       errors,
	output int unsigned                       pixels_pending,
	output int unsigned                       items_accepted
);
	import mer_pkg::*;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_right;
		logic signed [COORD_BITS-1:0] x_left;
		logic signed [COORD_BITS-1:0] y_upper;
		logic signed [COORD_BITS-1:0] y_lower;
		logic                         last_point;
	} pixel_t;

	logic [RADIUS_BITS-1:0] rad_x, rad_y, off_x, off_y;
	logic [REG_BITS-1:0]    ctr_x, ctr_y, max_y;
	logic [63:0]            dec;
	logic                   in_r2, walking;
	pixel_t                 pixels_due[$];
	int unsigned            mismatches, accepted;

	function automatic logic [63:0] square(input logic [RADIUS_BITS-1:0] r);
		return 64'(r) * 64'(r);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic plot_point();
		pixel_t px;
		px.x_right    = COORD_BITS'(64'(ctr_x) + 64'(off_x));
		px.x_left     = COORD_BITS'(64'(ctr_x) - 64'(off_x));
		px.y_upper    = COORD_BITS'(64'(max_y) - (64'(ctr_y) + 64'(off_y)));
		px.y_lower    = COORD_BITS'(64'(max_y) - (64'(ctr_y) - 64'(off_y)));
		px.last_point = (off_y == '0);
		if (off_y == '0)
			walking = 1'b0;
		pixels_due.push_back(px);
	endtask

	task automatic advance_curve(input logic restart);
		logic [63:0] a2, b2, inc, tx, ty;
		longint      lhs, rhs;
		a2 = square(rad_x);
		b2 = square(rad_y);
		if (restart) begin
			off_x   = '0;
			off_y   = rad_y;
			dec     = 4 * b2 + a2 - 4 * a2 * 64'(rad_y);
			in_r2   = 1'b0;
			walking = 1'b1;
			plot_point();
			return;
		end
		if (!walking)
			return;
		if (!in_r2) begin
			lhs = longint'(2 * b2 * (64'(off_x) + 1));
			rhs = longint'(a2 * (2 * 64'(off_y) - 1));
			if (lhs < rhs) begin
				inc = (2 * 64'(off_x) + 3) * b2;
				if (!dec[63]) begin
					inc += (2 - 2 * 64'(off_y)) * a2;
					off_y = off_y - 1'b1;
				end
				dec += 4 * inc;
				off_x = off_x + 1'b1;
				plot_point();
				return;
			end
			tx    = 2 * 64'(off_x) + 1;
			ty    = 64'(off_y) - 1;
			dec   = b2 * tx * tx + 4 * a2 * ty * ty - 4 * a2 * b2;
			in_r2 = 1'b1;
		end
		inc = (3 - 2 * 64'(off_y)) * a2;
		if (dec[63]) begin
			inc += (2 * 64'(off_x) + 2) * b2;
			off_x = off_x + 1'b1;
		end
		dec += 4 * inc;
		off_y = off_y - 1'b1;
		plot_point();
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixels_due.size() == 0) begin
			report_mismatch("pixel item with no point predicted");
			return;
		end
		want = pixels_due.pop_front();
		if (pixel.x_right !== want.x_right)
			report_mismatch($sformatf("x_right %0d, expected %0d", pixel.x_right, want.x_right));
		if (pixel.x_left !== want.x_left)
			report_mismatch($sformatf("x_left %0d, expected %0d", pixel.x_left, want.x_left));
		if (pixel.y_upper !== want.y_upper)
			report_mismatch($sformatf("y_upper %0d, expected %0d", pixel.y_upper, want.y_upper));
		if (pixel.y_lower !== want.y_lower)
			report_mismatch($sformatf("y_lower %0d, expected %0d", pixel.y_lower, want.y_lower));
		if (pixel.last_point !== want.last_point)
			report_mismatch($sformatf("last_point %0b, expected %0b", pixel.last_point,
				want.last_point));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_x      = '0;
			rad_y      = '0;
			ctr_x      = '0;
			ctr_y      = '0;
			max_y      = SCREEN_MAX_Y_RESET;
			off_x      = '0;
			off_y      = '0;
			dec        = '0;
			in_r2      = 1'b0;
			walking    = 1'b0;
			mismatches = 0;
			accepted   = 0;
			pixels_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIUS_X:     rad_x = cfg_wdata[RADIUS_BITS-1:0];
					CFG_RADIUS_Y:     rad_y = cfg_wdata[RADIUS_BITS-1:0];
					CFG_CENTER_X:     ctr_x = cfg_wdata[REG_BITS-1:0];
					CFG_CENTER_Y:     ctr_y = cfg_wdata[REG_BITS-1:0];
					CFG_SCREEN_MAX_Y: max_y = cfg_wdata[REG_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				advance_curve(cmd.restart);
				accepted++;
			end
			if (pixel.valid && pixel.ready)
				check_pixel();
		end
		errors         <= mismatches;
		pixels_pending <= pixels_due.size();
		items_accepted <= accepted;
	end

endmodule

/* tb/tb_midpoint_ellipse_rasterizer.sv */
`timescale 1ns / 1ps
// Top of the midpoint ellipse rasterizer testbench: clock, reset, register writes,
// cmd items and pixel back-pressure. Uses mer_pkg, mer_if.sv, the rasterizer and mer_checker.
module tb_midpoint_ellipse_rasterizer;
	import mer_pkg::*;

	localparam int ITEM_TARGET  = 900;
	localparam int PHASE_ITEMS  = 75;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic                     pressure_go;
	logic                     hold_off;
	int unsigned              idle_pct;
	int unsigned              stall_pct;
	int unsigned              errors, pixels_pending, items_accepted;

	mer_cmd_if   cmd();
	mer_pixel_if pixel();

	midpoint_ellipse_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.pixel     (pixel)
	);

	mer_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.pixel          (pixel),
		.errors         (errors),
		.pixels_pending (pixels_pending),
		.items_accepted (items_accepted)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		pixel.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// hold the receiver off for a long stretch so the block backs up into cmd
	initial begin
		hold_off = 1'b0;
		wait (pressure_go === 1'b1);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_BITS'(val);
		@(posedge clk);
	endtask

	task automatic set_shape(input int unsigned rx, input int unsigned ry, input int unsigned cx,
		input int unsigned cy, input int unsigned my);
		write_reg(CFG_RADIUS_X, rx | ($urandom_range(1) << RADIUS_BITS));
		write_reg(CFG_RADIUS_Y, ry | ($urandom_range(1) << RADIUS_BITS));
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_SCREEN_MAX_Y, my);
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1,
				int'(CFG_SCREEN_MAX_Y) + 1)), $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_cmd(input logic restart);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			cmd.valid   <= 1'b0;
			cmd.restart <= 1'($urandom_range(1));
			repeat (gap) @(posedge clk);
		end
		cmd.valid   <= 1'b1;
		cmd.restart <= restart;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	task automatic walk_curve(input int unsigned rx, input int unsigned ry);
		int unsigned steps;
		send_cmd(1'b1);
		if (rx + ry <= 64 && $urandom_range(7) != 0)
			steps = rx + ry + $urandom_range(2);
		else
			steps = $urandom_range((rx + ry < 48) ? rx + ry : 48);
		repeat (steps) send_cmd(1'b0);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned rx, ry, cx, cy, my, phase_start;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_RADIUS_X;
		cfg_wdata   <= '0;
		cmd.valid   <= 1'b0;
		cmd.restart <= 1'b0;
		pressure_go <= 1'b0;
		stall_pct   <= 0;
		idle_pct    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing running, then a zero-size curve under the reset registers
		send_cmd(1'b0);
		send_cmd(1'b1);
		send_cmd(1'b0);
		drain();
		// zero horizontal radius walks straight down
		set_shape(0, 3, 5, 2, 2047);
		send_cmd(1'b1);
		repeat (3) send_cmd(1'b0);
		drain();
		// largest radii and centers, screen_max_y 0 so the vertical coordinates go negative
		set_shape(1023, 1023, 2047, 2047, 0);
		send_cmd(1'b1);
		repeat (2) send_cmd(1'b0);
		drain();
		// full walk through the region switch, then a restart mid-curve
		set_shape(5, 2, 0, 0, 0);
		send_cmd(1'b1);
		repeat (7) send_cmd(1'b0);
		send_cmd(1'b1);
		send_cmd(1'b0);
		send_cmd(1'b1);
		send_cmd(1'b0);
		drain();

		for (int unsigned ph = 0; items_accepted < ITEM_TARGET; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 88; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 88; end
				default: begin idle_pct = 21; stall_pct <= 21; end
			endcase
			case ($urandom_range(9))
				0: begin
					rx = $urandom_range(1) ? 1023 : 0;
					ry = $urandom_range(1) ? 1023 : 0;
				end
				1, 2: begin
					rx = $urandom_range(1023);
					ry = $urandom_range(1023);
				end
				default: begin
					rx = $urandom_range(30);
					ry = $urandom_range(30);
				end
			endcase
			cx = $urandom_range(2047);
			cy = $urandom_range(2047);
			my = $urandom_range(1) ? 479 : $urandom_range(2047);
			set_shape(rx, ry, cx, cy, my);
			if (ph == 0)
				pressure_go <= 1'b1;
			phase_start = items_accepted;
			// carry on the previous curve under the new registers
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(6, 1)) send_cmd(1'b0);
			while (items_accepted - phase_start < PHASE_ITEMS)
				walk_curve(rx, ry);
			drain();
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
